// ===== hw/rtl/stxd_pkg.sv =====
// ----------------------------------------------------------------------------
// stxd_pkg
// Shared types, constants and helpers for the start/end byte deframer.
// ----------------------------------------------------------------------------
package stxd_pkg;

	// framing bytes
	localparam logic [7:0] START_BYTE = 8'h02;
	localparam logic [7:0] END_BYTE   = 8'h03;

	// store sizing
	localparam int BUFFER_SIZE = 16;
	localparam int STORE_DEPTH = BUFFER_SIZE - 1;
	localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(BUFFER_SIZE);

	// one result item
	typedef struct packed {
		logic [7:0] uid_byte;
		logic [3:0] byte_index;
		logic [3:0] frame_length;
		logic       last_of_frame;
		logic       empty_frame;
	} stxd_res_t;

	// load request from the sequencer into the output stage
	typedef struct packed {
		logic      load;
		stxd_res_t res;
	} stxd_load_t;

	// count or index narrowed or widened to a 4-bit field
	function automatic logic [3:0] to_nib(input logic [CNT_W-1:0] v);
		logic [CNT_W+3:0] t;
		t = {4'b0000, v};
		return t[3:0];
	endfunction

endpackage

// ===== hw/rtl/stxd_ram.sv =====
// ----------------------------------------------------------------------------
// stxd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stxd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/stxd_outreg.sv =====
// ----------------------------------------------------------------------------
// stxd_outreg
// Output register of the deframer: holds one result until it is taken.
// ----------------------------------------------------------------------------
module stxd_outreg (
	input  logic                clk,
	input  logic                arst_n,
	input  stxd_pkg::stxd_load_t ld,
	output logic                free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output stxd_pkg::stxd_res_t res
);
	import stxd_pkg::*;

	logic      valid_q;
	stxd_res_t res_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign res      = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld.load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ld.load) begin
			res_q <= ld.res;
		end
	end

endmodule

// ===== hw/rtl/stxd_ctrl.sv =====
// ----------------------------------------------------------------------------
// stxd_ctrl
// Frame sequencer: tracks the open frame, fills the store and walks it out.
// ----------------------------------------------------------------------------
module stxd_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	output logic                          wr_en,
	output logic [stxd_pkg::STORE_AW-1:0] wr_addr,
	output logic [7:0]                    wr_data,
	output logic                          rd_en,
	output logic [stxd_pkg::STORE_AW-1:0] rd_addr,
	input  logic [7:0]                    rd_data,
	input  logic                          out_free,
	output stxd_pkg::stxd_load_t          ld
);
	import stxd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_EMPTY
	} state_t;

	localparam logic [CNT_W-1:0] CAP = CNT_W'(STORE_DEPTH);

	state_t           state_q;
	logic             in_frame_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic             accept;
	logic             is_last;
	logic             not_full;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_last  = (idx_q + CNT_W'(1)) == count_q;
	assign not_full = count_q < CAP;

	// store write on a payload byte with room left
	assign wr_en   = accept && in_frame_q && not_full
		&& (s_tdata != START_BYTE) && (s_tdata != END_BYTE);
	assign wr_addr = count_q[STORE_AW-1:0];
	assign wr_data = s_tdata;

	// store read while walking out a frame
	assign rd_en   = (state_q == ST_READ);
	assign rd_addr = idx_q[STORE_AW-1:0];

	// result into the output stage
	always_comb begin
		ld = '0;
		case (state_q)
			ST_LOAD: begin
				ld.load               = out_free;
				ld.res.uid_byte       = rd_data;
				ld.res.byte_index     = to_nib(idx_q);
				ld.res.frame_length   = to_nib(count_q);
				ld.res.last_of_frame  = is_last;
				ld.res.empty_frame    = 1'b0;
			end
			ST_EMPTY: begin
				ld.load               = out_free;
				ld.res.last_of_frame  = 1'b1;
				ld.res.empty_frame    = 1'b1;
			end
			default: begin
				ld = '0;
			end
		endcase
	end

	// sequencer state and frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_frame_q <= 1'b0;
			count_q    <= '0;
			idx_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tdata == START_BYTE) begin
							count_q    <= '0;
							in_frame_q <= 1'b1;
						end else if (s_tdata == END_BYTE) begin
							if (in_frame_q) begin
								in_frame_q <= 1'b0;
								idx_q      <= '0;
								state_q    <= (count_q == '0) ? ST_EMPTY : ST_READ;
							end
						end else if (in_frame_q) begin
							if (not_full) begin
								count_q <= count_q + CNT_W'(1);
							end else begin
								// overlong payload drops the frame
								in_frame_q <= 1'b0;
								count_q    <= '0;
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/stx_etx_uid_deframer.sv =====
// ----------------------------------------------------------------------------
// stx_etx_uid_deframer
// Start/end byte frame decoder for identifier bytes from a serial reader.
// ----------------------------------------------------------------------------
// The slave channel takes one received byte per transfer. A 0x02 byte opens
// a frame (dropping any open one), payload bytes are stored up to 15, one
// more payload byte drops the frame, and 0x03 closes an open frame. The
// master channel then gives one transfer per stored byte, in order, with
// tlast on the final one; an empty frame gives a single transfer flagged
// empty in tuser. Bytes outside a frame give nothing.
// A closing byte starts the walk: the sequencer reads the store through its
// registered read port, passing through a read state and then a load state
// for each byte, while an empty frame goes straight to a single load state.
// The slave side is not ready while results are walked out.
// When the receiver stalls, the result waits in the output register and
// the walk holds; the next byte is taken while the last result still waits.
// Reset clears the frame state and the output valid; the store needs no
// clearing since only bytes written in the current frame are read.
// ----------------------------------------------------------------------------
module stx_etx_uid_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] uid_byte, [11:8] byte_index, [15:12] frame_length
	output logic        m_tlast,   // last_of_frame
	output logic [0:0]  m_tuser    // [0] empty_frame
);
	import stxd_pkg::*;

	logic                wr_en;
	logic [STORE_AW-1:0] wr_addr;
	logic [7:0]          wr_data;
	logic                rd_en;
	logic [STORE_AW-1:0] rd_addr;
	logic [7:0]          rd_data;
	logic                out_free;
	stxd_load_t          ld;
	stxd_res_t           res;

	// frame sequencer
	stxd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_free (out_free),
		.ld       (ld)
	);

	// payload store
	stxd_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH),
		.AW    (STORE_AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output register
	stxd_outreg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	// pack result onto the master channel
	assign m_tdata    = {res.frame_length, res.byte_index, res.uid_byte};
	assign m_tlast    = res.last_of_frame;
	assign m_tuser[0] = res.empty_frame;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the start/end byte identifier deframer.
// ----------------------------------------------------------------------------
// Feeds received bytes on the slave channel. The bytes form directed frames
// first, then mostly well-formed random frames mixed with overflowing,
// restarted and stray bytes. Both channels idle in random bursts. A
// scoreboard predicts every result transfer from the accepted bytes and
// checks each master transfer field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stxd_pkg::*;

	// tracks the frame state and holds the results still due
	class uid_scoreboard;
		stxd_res_t  due_q[$];
		logic [7:0] held[STORE_DEPTH];
		int         held_count = 0;
		bit         open = 1'b0;
		int         mismatches = 0;
		int         checked = 0;
		int         frames_closed = 0;

		// predict the results that an accepted byte causes
		function void note_rx_byte(logic [7:0] b);
			stxd_res_t r;
			int        n;
			if (b == START_BYTE) begin
				held_count = 0;
				open = 1'b1;
			end else if (b == END_BYTE) begin
				if (open) begin
					open = 1'b0;
					frames_closed++;
					n = held_count;
					if (n == 0) begin
						r = '0;
						r.last_of_frame = 1'b1;
						r.empty_frame = 1'b1;
						due_q.push_back(r);
					end else begin
						for (int k = 0; k < n; k++) begin
							r.uid_byte = held[k];
							r.byte_index = 4'(k);
							r.frame_length = 4'(n);
							r.last_of_frame = (k == n - 1);
							r.empty_frame = 1'b0;
							due_q.push_back(r);
						end
					end
				end
			end else if (open) begin
				// one byte past a full store drops the frame
				if (held_count < STORE_DEPTH) begin
					held[held_count] = b;
					held_count++;
				end else begin
					open = 1'b0;
					held_count = 0;
				end
			end
		endfunction

		function void flag(string what, stxd_res_t want, stxd_res_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s: expected byte %h idx %0d len %0d last %b empty %b, got byte %h idx %0d len %0d last %b empty %b",
					$realtime, what, want.uid_byte, want.byte_index, want.frame_length,
					want.last_of_frame, want.empty_frame, got.uid_byte, got.byte_index,
					got.frame_length, got.last_of_frame, got.empty_frame);
		endfunction

		// compare one master transfer with the oldest prediction
		function void check_result(stxd_res_t got);
			stxd_res_t want;
			checked++;
			if (due_q.size() == 0) begin
				flag("unexpected result", '0, got);
			end else begin
				want = due_q.pop_front();
				if (got.uid_byte !== want.uid_byte || got.byte_index !== want.byte_index ||
					got.frame_length !== want.frame_length ||
					got.last_of_frame !== want.last_of_frame ||
					got.empty_frame !== want.empty_frame)
					flag("result mismatch", want, got);
			end
		endfunction

		function void report_leftovers();
			while (due_q.size() != 0)
				flag("missing result", due_q.pop_front(), 'x);
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [7:0] uid_byte, [11:8] byte_index, [15:12] frame_length
	logic        m_tlast;           // last_of_frame
	logic [0:0]  m_tuser;           // [0] empty_frame

	uid_scoreboard sb = new();
	bit            calm = 1'b0;
	bit            no_idle = 1'b0;
	int            framed_bytes = 0;

	stx_etx_uid_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// one byte transfer on the slave channel, with an optional gap before it
	task automatic push_rx_byte(input logic [7:0] b);
		if (!no_idle && !calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_rx_byte(b);
	endtask

	// payload byte that is neither framing byte
	function automatic logic [7:0] rand_payload();
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		if (v == START_BYTE || v == END_BYTE)
			v = v ^ 8'h80;
		return v;
	endfunction

	task automatic send_frame(input int n, input bit close);
		push_rx_byte(START_BYTE);
		for (int i = 0; i < n; i++)
			push_rx_byte(rand_payload());
		if (close)
			push_rx_byte(END_BYTE);
		framed_bytes += n + 1 + int'(close);
	endtask

	// receiver: check transfers, stall in random bursts
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result('{m_tdata[7:0], m_tdata[11:8], m_tdata[15:12], m_tlast,
					m_tuser[0]});
			if (no_idle || calm) begin
				hold_left = 0;
				m_tready <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// stimulus and end of run
	initial begin
		int frame_no;
		int kind;
		int n;
		frame_no = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// bytes outside a frame are ignored
		push_rx_byte(END_BYTE);
		push_rx_byte(8'h55);
		// empty frame
		push_rx_byte(START_BYTE);
		push_rx_byte(END_BYTE);
		// extreme payload values
		push_rx_byte(START_BYTE);
		push_rx_byte(8'h00);
		push_rx_byte(8'hFF);
		push_rx_byte(END_BYTE);
		// start byte inside an open frame drops it
		push_rx_byte(START_BYTE);
		push_rx_byte(8'h41);
		push_rx_byte(START_BYTE);
		push_rx_byte(8'h42);
		push_rx_byte(END_BYTE);
		// bytes after a close are ignored
		push_rx_byte(8'h77);
		push_rx_byte(END_BYTE);

		// random frames, the first a full store and the second one byte over
		while (framed_bytes < 160) begin
			kind = $urandom_range(0, 99);
			calm = ($urandom_range(0, 3) == 0);
			if (framed_bytes >= 130)
				no_idle = 1'b1;
			if (frame_no == 0) begin
				send_frame(STORE_DEPTH, 1'b1);
			end else if (frame_no == 1 || (kind >= 70 && kind < 80)) begin
				send_frame(STORE_DEPTH + 1, 1'b1);
			end else if (kind < 70) begin
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, STORE_DEPTH)
					: $urandom_range(0, 5);
				send_frame(n, 1'b1);
			end else if (kind < 90) begin
				send_frame($urandom_range(0, 6), 1'b0);
				send_frame($urandom_range(0, 6), 1'b1);
			end else begin
				repeat ($urandom_range(1, 3)) begin
					n = $urandom_range(0, 255);
					push_rx_byte((8'(n) == START_BYTE) ? END_BYTE : 8'(n));
				end
			end
			frame_no++;
		end
		s_tvalid <= 1'b0;

		// drain
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		sb.report_leftovers();

		$display("covered %0d framed bytes in %0d closed frames, %0d result transfers checked",
			framed_bytes, sb.frames_closed, sb.checked);
		$display("mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/stxd_pkg.sv
hw/rtl/stxd_ram.sv
hw/rtl/stxd_outreg.sv
hw/rtl/stxd_ctrl.sv
hw/rtl/stx_etx_uid_deframer.sv
tb/tb.sv
